FILE: rtl/time_table_linear_interpolator_assert.svh
// assertion macros shared by the time table interpolator rtl
`ifndef TIME_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TIME_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define TTI_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen outside reset
`define TTI_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TTI_ASSERT(lbl, clk, rstn, prop, msg)
`define TTI_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/tti_pkg.sv
// shared constants, types and helpers of the time table interpolator
package tti_pkg;

	localparam int TABLE_ROWS    = 1024;
	localparam int VALUE_COLUMNS = 4;
	localparam int ROW_WORDS     = VALUE_COLUMNS + 1;
	localparam int TBL_DEPTH     = TABLE_ROWS * ROW_WORDS;
	localparam int TBL_AW        = $clog2(TBL_DEPTH);
	localparam int ROW_W         = 10;
	localparam int CNT_W         = 11;
	localparam int COL_W         = 3;
	localparam int VCOL_W        = 2;
	localparam int ONE_Q16       = 65536;
	localparam int FACT_W        = 17;
	localparam int TM_W          = 36;
	localparam int DIVS_W        = 33;
	localparam int DIVD_W        = DIVS_W + 16;
	localparam int DIV_CNT_W     = $clog2(DIVD_W + 1);
	localparam int PROD_W        = FACT_W + 1 + 33;
	localparam int IN_DATA_W     = 80;
	localparam int OUT_DATA_W    = 32;

	// request kinds on the input tuser
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// configuration register indexes
	localparam logic CFG_REPEAT = 1'b0;
	localparam logic CFG_ROWS   = 1'b1;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// flat word address of one table cell
	function automatic logic [TBL_AW-1:0] row_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [TBL_AW-1:0] a;
		a = TBL_AW'(row) * TBL_AW'(ROW_WORDS) + TBL_AW'(col);
		return a;
	endfunction

endpackage

FILE: rtl/tti_mem.sv
// table word memory, one write port and one registered read port
module tti_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [tti_pkg::TBL_AW-1:0] waddr,
	input  logic [31:0]               wdata,
	input  logic [tti_pkg::TBL_AW-1:0] raddr,
	output logic [31:0]               rdata_q
);
	import tti_pkg::*;

	logic [31:0] mem_q [TBL_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

endmodule

FILE: rtl/tti_div.sv
// restoring divider, one quotient bit per cycle
module tti_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tti_pkg::DIVD_W-1:0] dividend,
	input  logic [tti_pkg::DIVS_W-1:0] divisor,
	output tti_pkg::div_stat_t         stat,
	output logic [tti_pkg::DIVD_W-1:0] quotient,
	output logic [tti_pkg::DIVS_W-1:0] remainder
);
	import tti_pkg::*;

	logic [DIVD_W-1:0]    dq_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVS_W:0]      r2;
	logic [DIVS_W:0]      diff;
	logic                 qbit;

	// one trial subtraction
	always_comb begin
		r2   = {rem_q, dq_q[DIVD_W-1]};
		diff = r2 - {1'b0, dsr_q};
		qbit = (r2 >= {1'b0, dsr_q});
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q   <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dq_q   <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
				cnt_q  <= DIV_CNT_W'(DIVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? diff[DIVS_W-1:0] : r2[DIVS_W-1:0];
				dq_q  <= {dq_q[DIVD_W-2:0], qbit};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

FILE: rtl/time_table_linear_interpolator.sv
// Time table interpolator top level: sequencer, table memory and shared divider.
// A load request writes one table word. An evaluate request reads the last row
// time and, unless the query lies past the end with repeat off, the first row
// time, walks the scan pointer one row at a time (one table read port with
// registered address and data), then reads the bracketing rows and emits one
// result per value column, waiting on m_tready for each. Each division (negative
// time modulo span, multi-span wrap, interpolation factor) runs in the bit-serial
// divider, and a wrap adds a sweep over the rows in use. s_tready is high only
// while the block is idle. The table is not cleared by reset.
module time_table_linear_interpolator (
	input  logic                            clk,
	input  logic                            arst_n,
	// tdata: row_index, column_index, write_value, query_time, zero pad
	input  logic [tti_pkg::IN_DATA_W-1:0]   s_tdata,
	// tuser: command
	input  logic                            s_tuser,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata: interpolated_value
	output logic [tti_pkg::OUT_DATA_W-1:0]  m_tdata,
	// tuser: value_column
	output logic [tti_pkg::VCOL_W-1:0]      m_tuser,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tti_pkg::CNT_W-1:0]       cfg_data
);
	import tti_pkg::*;
	`include "time_table_linear_interpolator_assert.svh"

	typedef enum logic [4:0] {
		S_IDLE, S_WAIT, S_TLAST, S_T0, S_MOD, S_WALK, S_WALK_CMP, S_MAX, S_MAX_CMP,
		S_MAXDIV, S_PREV, S_NEXT, S_FDIV, S_COL_P, S_COL_N, S_MUL, S_SUM, S_OUT
	} state_t;

	state_t state_q, ret_q;

	// input fields
	logic [ROW_W-1:0]  in_row;
	logic [COL_W-1:0]  in_col;
	logic [31:0]       in_wval;
	logic [31:0]       in_qtime;
	logic              s_acc;

	assign in_row   = s_tdata[9:0];
	assign in_col   = s_tdata[12:10];
	assign in_wval  = s_tdata[44:13];
	assign in_qtime = s_tdata[76:45];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// configuration and kept state
	logic               repeat_q;
	logic [CNT_W-1:0]   row_count_q;
	logic [ROW_W-1:0]   scan_q;
	logic [31:0]        offset_q;

	// working registers
	logic signed [31:0]       q_q, tlast_q, t0_q, maxt_q, tp_q, tn_q, pv_q, nv_q;
	logic signed [32:0]       span_q;
	logic signed [TM_W-1:0]   tm_q;
	logic [31:0]              off_q;
	logic [CNT_W-1:0]         n_q, j_q;
	logic                     pass2_q;
	logic [ROW_W-1:0]         prev_q, next_q;
	logic [FACT_W-1:0]        factor_q;
	logic [VCOL_W-1:0]        col_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [TBL_AW-1:0]        addr_q;
	logic [31:0]              m_tdata_q;
	logic [VCOL_W-1:0]        m_tuser_q;
	logic                     m_tlast_q, m_tvalid_q;

	// shared divider
	logic              div_start_q;
	logic [DIVD_W-1:0] div_dvd_q;
	logic [DIVS_W-1:0] div_dsr_q;
	div_stat_t         div_stat;
	logic [DIVD_W-1:0] div_quo;
	logic [DIVS_W-1:0] div_rem;

	// table memory
	logic              mem_we;
	logic [31:0]       mem_rdata;

	assign mem_we = s_acc && (s_tuser == CMD_LOAD) && (in_col <= COL_W'(VALUE_COLUMNS))
		&& ({1'b0, in_row} < CNT_W'(TABLE_ROWS));

	tti_mem u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (row_addr(in_row, in_col)),
		.wdata   (in_wval),
		.raddr   (addr_q),
		.rdata_q (mem_rdata)
	);

	tti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dvd_q),
		.divisor   (div_dsr_q),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// arithmetic around the sequencer
	logic [CNT_W-1:0]         n_eff;
	logic [ROW_W-1:0]         last_row;
	logic signed [31:0]       rd_t;
	logic signed [32:0]       span_c, tm33_c, den_c, diff_c;
	logic [31:0]              q_abs;
	logic signed [TM_W-1:0]   rem_ext, span_ext, maxt_ext, d_c, num_c, fix_c;
	logic [TM_W-1:0]          un_c;
	logic [DIVS_W-1:0]        ud_c;
	logic [ROW_W-1:0]         fin_j, fin_prev;
	logic signed [PROD_W-1:0] rnd_c;
	logic signed [TM_W-1:0]   v_c;
	logic [31:0]              sat_c;
	logic                     col_last;

	localparam logic signed [TM_W-1:0] V_MAX = TM_W'(64'sd2147483647);
	localparam logic signed [TM_W-1:0] V_MIN = TM_W'(-64'sd2147483648);

	always_comb begin
		if (row_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (row_count_q > CNT_W'(TABLE_ROWS)) begin
			n_eff = CNT_W'(TABLE_ROWS);
		end else begin
			n_eff = row_count_q;
		end
		last_row = ROW_W'(n_eff - CNT_W'(1));
		rd_t     = $signed(mem_rdata);
		span_c   = {tlast_q[31], tlast_q} - {rd_t[31], rd_t};
		tm33_c   = {q_q[31], q_q} - {off_q[31], off_q};
		q_abs    = q_q[31] ? (~q_q + 32'd1) : q_q;
		rem_ext  = $signed({{(TM_W-DIVS_W){1'b0}}, div_rem});
		span_ext = TM_W'(span_q);
		maxt_ext = TM_W'(maxt_q);
		d_c      = tm_q - maxt_ext;
		fix_c    = d_c + span_ext - TM_W'(1) - rem_ext;
		num_c    = tm_q - TM_W'(tp_q);
		den_c    = {tn_q[31], tn_q} - {tp_q[31], tp_q};
		un_c     = num_c[TM_W-1] ? $unsigned(-num_c) : $unsigned(num_c);
		ud_c     = den_c[32] ? $unsigned(-den_c) : $unsigned(den_c);
		fin_j    = (state_q == S_WALK) ? '0 : j_q[ROW_W-1:0];
		fin_prev = (fin_j == '0) ? fin_j : fin_j - 1'b1;
		diff_c   = {nv_q[31], nv_q} - {pv_q[31], pv_q};
		rnd_c    = prod_q + PROD_W'(ONE_Q16 / 2);
		v_c      = TM_W'(pv_q) + TM_W'($signed(rnd_c[PROD_W-1:16]));
		if (v_c > V_MAX) begin
			sat_c = 32'h7FFF_FFFF;
		end else if (v_c < V_MIN) begin
			sat_c = 32'h8000_0000;
		end else begin
			sat_c = v_c[31:0];
		end
		col_last = (col_q == VCOL_W'(VALUE_COLUMNS - 1));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			repeat_q    <= 1'b0;
			row_count_q <= CNT_W'(1);
			scan_q      <= '0;
			offset_q    <= '0;
			q_q         <= '0;
			tlast_q     <= '0;
			t0_q        <= '0;
			maxt_q      <= '0;
			tp_q        <= '0;
			tn_q        <= '0;
			pv_q        <= '0;
			nv_q        <= '0;
			span_q      <= '0;
			tm_q        <= '0;
			off_q       <= '0;
			n_q         <= '0;
			j_q         <= '0;
			pass2_q     <= 1'b0;
			prev_q      <= '0;
			next_q      <= '0;
			factor_q    <= '0;
			col_q       <= '0;
			prod_q      <= '0;
			addr_q      <= '0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
			m_tlast_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
			div_start_q <= 1'b0;
			div_dvd_q   <= '0;
			div_dsr_q   <= '0;
		end else begin
			div_start_q <= 1'b0;
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_REPEAT: repeat_q    <= cfg_data[0];
					CFG_ROWS:   row_count_q <= cfg_data;
					default:    ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc && s_tuser == CMD_EVAL) begin
						q_q     <= $signed(in_qtime);
						n_q     <= n_eff;
						off_q   <= offset_q;
						addr_q  <= row_addr(last_row, COL_W'(0));
						ret_q   <= S_TLAST;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= ret_q;
				end
				S_TLAST: begin
					tlast_q <= rd_t;
					if (!repeat_q && q_q > rd_t) begin
						// hold the last row past the end
						prev_q   <= ROW_W'(n_q - CNT_W'(1));
						next_q   <= ROW_W'(n_q - CNT_W'(1));
						factor_q <= '0;
						col_q    <= '0;
						addr_q   <= row_addr(ROW_W'(n_q - CNT_W'(1)), COL_W'(1));
						ret_q    <= S_COL_P;
					end else begin
						addr_q <= row_addr('0, COL_W'(0));
						ret_q  <= S_T0;
					end
					state_q <= S_WAIT;
				end
				S_T0: begin
					t0_q   <= rd_t;
					span_q <= span_c;
					if (span_c <= 33'sd0) begin
						// empty span holds row zero
						scan_q   <= '0;
						prev_q   <= '0;
						next_q   <= '0;
						factor_q <= '0;
						col_q    <= '0;
						addr_q   <= row_addr('0, COL_W'(1));
						ret_q    <= S_COL_P;
						state_q  <= S_WAIT;
					end else if (tm33_c < 33'sd0) begin
						// time before the offset: fold by the span
						scan_q      <= '0;
						div_dvd_q   <= DIVD_W'(q_abs);
						div_dsr_q   <= $unsigned(span_c);
						div_start_q <= 1'b1;
						state_q     <= S_MOD;
					end else begin
						tm_q    <= TM_W'(tm33_c);
						j_q     <= ({1'b0, scan_q} >= n_q) ? '0 : {1'b0, scan_q};
						pass2_q <= 1'b0;
						state_q <= S_WALK;
					end
				end
				S_MOD: begin
					if (div_stat.done) begin
						tm_q    <= q_q[31] ? -rem_ext : rem_ext;
						j_q     <= '0;
						pass2_q <= 1'b0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (j_q < n_q) begin
						addr_q  <= row_addr(j_q[ROW_W-1:0], COL_W'(0));
						ret_q   <= S_WALK_CMP;
						state_q <= S_WAIT;
					end else if (pass2_q) begin
						// no row after wrap: restart at row zero
						offset_q <= off_q;
						scan_q   <= fin_j;
						next_q   <= fin_j;
						prev_q   <= fin_prev;
						addr_q   <= row_addr(fin_prev, COL_W'(0));
						ret_q    <= S_PREV;
						state_q  <= S_WAIT;
					end else begin
						// wrap once, then find the largest row time
						tm_q    <= tm_q - span_ext;
						off_q   <= off_q + span_q[31:0];
						maxt_q  <= t0_q;
						j_q     <= CNT_W'(1);
						state_q <= S_MAX;
					end
				end
				S_WALK_CMP: begin
					if (tm_q <= TM_W'(rd_t)) begin
						if (pass2_q) begin
							offset_q <= off_q;
						end
						scan_q  <= fin_j;
						next_q  <= fin_j;
						prev_q  <= fin_prev;
						addr_q  <= row_addr(fin_prev, COL_W'(0));
						ret_q   <= S_PREV;
						state_q <= S_WAIT;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_WALK;
					end
				end
				S_MAX: begin
					if (j_q < n_q) begin
						addr_q  <= row_addr(j_q[ROW_W-1:0], COL_W'(0));
						ret_q   <= S_MAX_CMP;
						state_q <= S_WAIT;
					end else if (tm_q > maxt_ext) begin
						// several spans at once through the divider
						div_dvd_q   <= DIVD_W'($unsigned(d_c - TM_W'(1)));
						div_dsr_q   <= $unsigned(span_q);
						div_start_q <= 1'b1;
						state_q     <= S_MAXDIV;
					end else begin
						j_q     <= '0;
						pass2_q <= 1'b1;
						state_q <= S_WALK;
					end
				end
				S_MAX_CMP: begin
					if (rd_t > maxt_q) begin
						maxt_q <= rd_t;
					end
					j_q     <= j_q + 1'b1;
					state_q <= S_MAX;
				end
				S_MAXDIV: begin
					if (div_stat.done) begin
						tm_q    <= maxt_ext - span_ext + TM_W'(1) + rem_ext;
						off_q   <= off_q + fix_c[31:0];
						j_q     <= '0;
						pass2_q <= 1'b1;
						state_q <= S_WALK;
					end
				end
				S_PREV: begin
					tp_q    <= rd_t;
					addr_q  <= row_addr(next_q, COL_W'(0));
					ret_q   <= S_NEXT;
					state_q <= S_WAIT;
				end
				S_NEXT: begin
					// factor decided in the next state once both times are held
					tn_q     <= rd_t;
					col_q    <= '0;
					factor_q <= '0;
					addr_q   <= row_addr(prev_q, COL_W'(1));
					ret_q    <= S_COL_P;
					// first pass through S_FDIV starts or skips the division
					pass2_q  <= 1'b1;
					state_q  <= S_FDIV;
				end
				S_FDIV: begin
					if (pass2_q) begin
						// one-time factor setup
						pass2_q <= 1'b0;
						if (den_c == 33'sd0 || num_c == '0
							|| (num_c[TM_W-1] != den_c[32])) begin
							factor_q <= '0;
							state_q  <= S_WAIT;
						end else if (un_c >= TM_W'(ud_c)) begin
							factor_q <= FACT_W'(ONE_Q16);
							state_q  <= S_WAIT;
						end else begin
							div_dvd_q   <= {un_c[DIVS_W-1:0], 16'd0};
							div_dsr_q   <= ud_c;
							div_start_q <= 1'b1;
						end
					end else if (div_stat.done) begin
						factor_q <= div_quo[FACT_W-1:0];
						state_q  <= S_WAIT;
					end
				end
				S_COL_P: begin
					pv_q    <= rd_t;
					addr_q  <= row_addr(next_q, COL_W'(col_q) + COL_W'(1));
					ret_q   <= S_COL_N;
					state_q <= S_WAIT;
				end
				S_COL_N: begin
					nv_q    <= rd_t;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= $signed({1'b0, factor_q}) * diff_c;
					state_q <= S_SUM;
				end
				S_SUM: begin
					m_tdata_q  <= sat_c;
					m_tuser_q  <= col_q;
					m_tlast_q  <= col_last;
					m_tvalid_q <= 1'b1;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (col_last) begin
							state_q <= S_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							addr_q  <= row_addr(prev_q, COL_W'(col_q) + COL_W'(2));
							ret_q   <= S_COL_P;
							state_q <= S_WAIT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign m_tvalid = m_tvalid_q;

	// checks
	`TTI_NEVER(a_idle_no_result, clk, arst_n, s_tready && m_tvalid, "result pending while idle")
	`TTI_ASSERT(a_last_col, clk, arst_n, (m_tvalid && m_tlast) |-> (m_tuser == VCOL_W'(VALUE_COLUMNS - 1)), "last flag on wrong column")
	`TTI_NEVER(a_factor_range, clk, arst_n, factor_q > FACT_W'(ONE_Q16), "factor above one")
	`TTI_NEVER(a_div_overlap, clk, arst_n, div_start_q && div_stat.busy, "divider restarted while busy")

endmodule
